/* hdl/stu_pkg.sv */
`timescale 1ns / 1ps

package stu_pkg;

   localparam int CharWidth = 8;
   localparam int MaskRegs = 4;
   localparam int MaskRegWidth = 64;
   localparam int MaskIndexWidth = $clog2(MaskRegs);
   localparam int MaskBits = MaskRegs * MaskRegWidth;

   localparam int FifoDepth = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCountWidth = $clog2(FifoDepth + 1);

   localparam logic [CharWidth-1:0] ChNul = 8'h00;
   localparam logic [CharWidth-1:0] ChBs = 8'h08;
   localparam logic [CharWidth-1:0] ChTab = 8'h09;
   localparam logic [CharWidth-1:0] ChLf = 8'h0A;
   localparam logic [CharWidth-1:0] ChCr = 8'h0D;
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChQuote = 8'h22;
   localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;
   localparam logic [CharWidth-1:0] ChLowerB = 8'h62;
   localparam logic [CharWidth-1:0] ChLowerN = 8'h6E;
   localparam logic [CharWidth-1:0] ChLowerR = 8'h72;
   localparam logic [CharWidth-1:0] ChLowerT = 8'h74;

   localparam logic KindData = 1'b0;
   localparam logic KindEnd = 1'b1;

   typedef struct packed {
      logic kind;
      logic [CharWidth-1:0] value;
      logic end_consumed;
      logic was_quoted;
      logic last;
   } result_type;

   // up to two results come out of one character
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } decode_type;

endpackage

/* hdl/string_token_unescape.sv */
`timescale 1ns / 1ps
// a taken character is held in the input register, decoded and written into the result queue
// throughput: one character per cycle while the result queue has room; a character that
// gives two words (octal run ended by another byte) writes both into the queue at once
// a four-word result queue decouples the sides; input stalls when fewer than two slots are free
// reset (synchronous, active high) clears the parser to idle, empties the queue and
// zeroes the extra terminator masks

module string_token_unescape (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [stu_pkg::CharWidth-1:0] req_ch,
   input  logic req_start_token,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_kind,
   output logic [stu_pkg::CharWidth-1:0] rsp_value,
   output logic rsp_end_consumed,
   output logic rsp_was_quoted,
   output logic rsp_last,
   input  logic csr_wr_en,
   input  logic [stu_pkg::MaskIndexWidth-1:0] csr_index,
   input  logic [stu_pkg::MaskRegWidth-1:0] csr_wdata
);

   logic [stu_pkg::MaskRegs-1:0][stu_pkg::MaskRegWidth-1:0] term_ff;
   logic in_valid_ff;
   logic [stu_pkg::CharWidth-1:0] in_ch_ff;
   logic in_start_ff;
   logic fire, room, take;
   stu_pkg::decode_type dec;
   stu_pkg::result_type out_word;

   assign fire = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else if (csr_wr_en) begin
         term_ff[csr_index] <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ch_ff <= req_ch;
         in_start_ff <= req_start_token;
      end
   end

   stu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .ch          (in_ch_ff),
      .start_token (in_start_ff),
      .term_mask   (term_ff),
      .dec         (dec)
   );

   stu_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .dec       (dec),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_kind = out_word.kind;
   assign rsp_value = out_word.value;
   assign rsp_end_consumed = out_word.end_consumed;
   assign rsp_was_quoted = out_word.was_quoted;
   assign rsp_last = out_word.last;

endmodule

/* hdl/stu_decode.sv */
`timescale 1ns / 1ps

module stu_decode (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  logic [stu_pkg::CharWidth-1:0] ch,
   input  logic start_token,
   input  logic [stu_pkg::MaskBits-1:0] term_mask,
   output stu_pkg::decode_type dec
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WS     = 3'd1,
      PH_RAW    = 3'd2,
      PH_QUOTED = 3'd3,
      PH_ESC    = 3'd4,
      PH_OCT    = 3'd5
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0] oct_value_ff, oct_value_in;
   logic [1:0] oct_count_ff, oct_count_in;

   phase_type phase_eff;
   logic [7:0] oct_value_eff;
   logic [1:0] oct_count_eff;

   stu_pkg::result_type raw_res, q_res, r0, r1;
   logic [1:0] n;
   logic raw_stop;
   phase_type raw_next, q_next;
   logic q_end, q_close, q_esc, q_emit;
   logic is_digit;
   logic [7:0] oct_next;

   // raw mode terminator
   always_comb begin
      raw_stop = (ch <= stu_pkg::ChSpace) || term_mask[ch];
      raw_res = '0;
      raw_res.kind = raw_stop ? stu_pkg::KindEnd : stu_pkg::KindData;
      raw_res.value = raw_stop ? '0 : ch;
      raw_next = raw_stop ? PH_IDLE : PH_RAW;
   end

   // one character inside quotes
   always_comb begin
      q_end = (ch == stu_pkg::ChNul) || (ch == stu_pkg::ChLf) || (ch == stu_pkg::ChCr);
      q_close = (ch == stu_pkg::ChQuote);
      q_esc = (ch == stu_pkg::ChBackslash);
      q_emit = !q_esc;
      q_res = '0;
      q_res.kind = (q_end || q_close) ? stu_pkg::KindEnd : stu_pkg::KindData;
      q_res.value = (q_end || q_close) ? '0 : ch;
      q_res.end_consumed = q_close;
      q_res.was_quoted = 1'b1;
      if (q_end || q_close) begin
         q_next = PH_IDLE;
      end else if (q_esc) begin
         q_next = PH_ESC;
      end else begin
         q_next = PH_QUOTED;
      end
   end

   always_comb begin
      phase_eff = start_token ? PH_WS : phase_ff;
      oct_value_eff = start_token ? '0 : oct_value_ff;
      oct_count_eff = start_token ? '0 : oct_count_ff;
      is_digit = (ch[7:3] == 5'b00110);
      // low three bits of the shifted value are zero, so the add is a concatenation
      oct_next = {oct_value_eff[4:0], ch[2:0]};

      phase_in = phase_eff;
      oct_value_in = oct_value_eff;
      oct_count_in = oct_count_eff;
      n = 2'd0;
      r0 = '0;
      r1 = '0;

      case (phase_eff)
         PH_WS: begin
            if ((ch == stu_pkg::ChSpace) || (ch == stu_pkg::ChTab) ||
                (ch == stu_pkg::ChLf) || (ch == stu_pkg::ChCr)) begin
               phase_in = PH_WS;
            end else if (ch == stu_pkg::ChQuote) begin
               phase_in = PH_QUOTED;
            end else begin
               n = 2'd1;
               r0 = raw_res;
               phase_in = raw_next;
            end
         end
         PH_RAW: begin
            n = 2'd1;
            r0 = raw_res;
            phase_in = raw_next;
         end
         PH_QUOTED: begin
            n = {1'b0, q_emit};
            r0 = q_res;
            phase_in = q_next;
         end
         PH_ESC: begin
            phase_in = PH_QUOTED;
            r0.was_quoted = 1'b1;
            if (ch == stu_pkg::ChNul) begin
               n = 2'd1;
               r0.kind = stu_pkg::KindEnd;
               phase_in = PH_IDLE;
            end else if (ch == stu_pkg::ChLowerN) begin
               n = 2'd1;
               r0.value = stu_pkg::ChLf;
            end else if (ch == stu_pkg::ChLowerR) begin
               n = 2'd1;
               r0.value = stu_pkg::ChCr;
            end else if (ch == stu_pkg::ChLowerT) begin
               n = 2'd1;
               r0.value = stu_pkg::ChTab;
            end else if (ch == stu_pkg::ChLowerB) begin
               n = 2'd1;
               r0.value = stu_pkg::ChBs;
            end else if (is_digit) begin
               oct_value_in = {5'd0, ch[2:0]};
               oct_count_in = 2'd1;
               phase_in = PH_OCT;
            end else if (ch == stu_pkg::ChLf) begin
               // line continuation, nothing emitted
               phase_in = PH_QUOTED;
            end else begin
               n = 2'd1;
               r0.value = ch;
            end
         end
         PH_OCT: begin
            r0.was_quoted = 1'b1;
            if (is_digit) begin
               if (oct_count_eff == 2'd2) begin
                  n = 2'd1;
                  r0.value = oct_next;
                  oct_value_in = '0;
                  oct_count_in = '0;
                  phase_in = PH_QUOTED;
               end else begin
                  oct_value_in = oct_next;
                  oct_count_in = oct_count_eff + 2'd1;
               end
            end else begin
               // flush the octal byte, then treat this one as a quoted character
               r0.value = oct_value_eff;
               r1 = q_res;
               n = q_emit ? 2'd2 : 2'd1;
               oct_value_in = '0;
               oct_count_in = '0;
               phase_in = q_next;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end

      dec.count = n;
      dec.res0 = r0;
      dec.res1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         oct_value_ff <= '0;
         oct_count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         oct_value_ff <= oct_value_in;
         oct_count_ff <= oct_count_in;
      end
   end

endmodule

/* hdl/stu_result_fifo.sv */
`timescale 1ns / 1ps

module stu_result_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  stu_pkg::decode_type dec,
   output logic room,
   output logic out_valid,
   input  logic out_stall,
   output stu_pkg::result_type out_word
);

   stu_pkg::result_type mem_ff [stu_pkg::FifoDepth];
   logic [stu_pkg::FifoPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stu_pkg::FifoPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stu_pkg::FifoCountWidth-1:0] count_ff, count_in;
   logic [1:0] push_n;
   logic pop;

   // two free slots needed, an item can leave two words
   assign room = (count_ff <= stu_pkg::FifoCountWidth'(stu_pkg::FifoDepth - 2));
   assign out_valid = (count_ff != '0);
   assign out_word = mem_ff[rd_ptr_ff];
   assign pop = out_valid && !out_stall;
   assign push_n = push ? dec.count : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + stu_pkg::FifoPtrWidth'(push_n);
      rd_ptr_in = rd_ptr_ff + stu_pkg::FifoPtrWidth'(pop);
      count_in = count_ff + stu_pkg::FifoCountWidth'(push_n)
                 - stu_pkg::FifoCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= dec.res0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + stu_pkg::FifoPtrWidth'(1)] <= dec.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   typedef enum logic [2:0] {
      PhIdle, PhSkipBlank, PhRaw, PhQuoted, PhEscape, PhOctal
   } parse_phase_type;

   typedef enum int {StallNone, StallRandom, StallPattern} stall_mode_type;

   localparam logic [stu_pkg::CharWidth-1:0] ChZero = 8'h30;
   localparam logic [stu_pkg::CharWidth-1:0] ChSeven = 8'h37;
   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 150;
   localparam int SettleCycles = 8;
   localparam int MaskSettings = 5;
   localparam int CharsPerSetting = 110;
   localparam int PressureChars = 48;
   localparam int MaxErrorLines = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [stu_pkg::CharWidth-1:0] req_ch = '0;
   logic req_start_token = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [stu_pkg::CharWidth-1:0] rsp_value;
   logic rsp_end_consumed;
   logic rsp_was_quoted;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [stu_pkg::MaskIndexWidth-1:0] csr_index = '0;
   logic [stu_pkg::MaskRegWidth-1:0] csr_wdata = '0;

   string_token_unescape u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_ch(req_ch),
      .req_start_token(req_start_token),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_value(rsp_value),
      .rsp_end_consumed(rsp_end_consumed),
      .rsp_was_quoted(rsp_was_quoted),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as the block should hold it
   parse_phase_type ph = PhIdle;
   logic [stu_pkg::CharWidth-1:0] oct_val = '0;
   int oct_cnt = 0;
   logic [stu_pkg::MaskRegWidth-1:0] term_mask [stu_pkg::MaskRegs] = '{default: '0};
   logic [stu_pkg::MaskRegWidth-1:0] mask_plan [stu_pkg::MaskRegs];
   stu_pkg::result_type expected_words [$];
   logic [stu_pkg::CharWidth-1:0] token_chars [$];

   int errors = 0;
   int words_checked = 0;
   int chars_taken = 0;
   int useful_chars = 0;
   int tokens_sent = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_max = 4;
   stall_mode_type stall_mode = StallNone;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic [12:0] stall_pat = 13'b1100100011010;
   stu_pkg::result_type got_word;
   stu_pkg::result_type want_word;

   function automatic void append_word(stu_pkg::result_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void add_char(logic [stu_pkg::CharWidth-1:0] c);
      token_chars.insert(token_chars.size(), c);
   endfunction

   function automatic void expect_word(logic kind, logic [stu_pkg::CharWidth-1:0] v,
                                       logic consumed, logic quoted);
      stu_pkg::result_type w;
      w.kind = kind;
      w.value = v;
      w.end_consumed = consumed;
      w.was_quoted = quoted;
      w.last = 1'b0;
      append_word(w);
   endfunction

   function automatic logic raw_terminator(logic [stu_pkg::CharWidth-1:0] c);
      return (c <= stu_pkg::ChSpace) || term_mask[c[7:6]][c[5:0]];
   endfunction

   function automatic void raw_byte(logic [stu_pkg::CharWidth-1:0] c);
      if (raw_terminator(c)) begin
         expect_word(stu_pkg::KindEnd, '0, 1'b0, 1'b0);
         ph = PhIdle;
      end else begin
         expect_word(stu_pkg::KindData, c, 1'b0, 1'b0);
      end
   endfunction

   function automatic void quoted_byte(logic [stu_pkg::CharWidth-1:0] c);
      if (c == stu_pkg::ChNul || c == stu_pkg::ChLf || c == stu_pkg::ChCr) begin
         expect_word(stu_pkg::KindEnd, '0, 1'b0, 1'b1);
         ph = PhIdle;
      end else if (c == stu_pkg::ChQuote) begin
         expect_word(stu_pkg::KindEnd, '0, 1'b1, 1'b1);
         ph = PhIdle;
      end else if (c == stu_pkg::ChBackslash) begin
         ph = PhEscape;
      end else begin
         expect_word(stu_pkg::KindData, c, 1'b0, 1'b1);
      end
   endfunction

   function automatic void decode_char(logic [stu_pkg::CharWidth-1:0] c, logic st);
      int size_was;
      stu_pkg::result_type tail;
      size_was = expected_words.size();
      if (st) begin
         ph = PhSkipBlank;
         oct_val = '0;
         oct_cnt = 0;
      end
      case (ph)
         PhSkipBlank: begin
            if (c == stu_pkg::ChQuote) begin
               ph = PhQuoted;
            end else if (!(c == stu_pkg::ChSpace || c == stu_pkg::ChTab ||
                           c == stu_pkg::ChLf || c == stu_pkg::ChCr)) begin
               ph = PhRaw;
               raw_byte(c);
            end
         end
         PhRaw: raw_byte(c);
         PhQuoted: quoted_byte(c);
         PhEscape: begin
            ph = PhQuoted;
            if (c == stu_pkg::ChNul) begin
               expect_word(stu_pkg::KindEnd, '0, 1'b0, 1'b1);
               ph = PhIdle;
            end else if (c == stu_pkg::ChLowerN) begin
               expect_word(stu_pkg::KindData, stu_pkg::ChLf, 1'b0, 1'b1);
            end else if (c == stu_pkg::ChLowerR) begin
               expect_word(stu_pkg::KindData, stu_pkg::ChCr, 1'b0, 1'b1);
            end else if (c == stu_pkg::ChLowerT) begin
               expect_word(stu_pkg::KindData, stu_pkg::ChTab, 1'b0, 1'b1);
            end else if (c == stu_pkg::ChLowerB) begin
               expect_word(stu_pkg::KindData, stu_pkg::ChBs, 1'b0, 1'b1);
            end else if (c >= ChZero && c <= ChSeven) begin
               oct_val = c - ChZero;
               oct_cnt = 1;
               ph = PhOctal;
            end else if (c != stu_pkg::ChLf) begin
               // backslash-newline is a line continuation and gives nothing
               expect_word(stu_pkg::KindData, c, 1'b0, 1'b1);
            end
         end
         PhOctal: begin
            if (c >= ChZero && c <= ChSeven) begin
               oct_val = (oct_val << 3) + (c - ChZero);
               oct_cnt++;
               if (oct_cnt >= 3) begin
                  expect_word(stu_pkg::KindData, oct_val, 1'b0, 1'b1);
                  oct_val = '0;
                  oct_cnt = 0;
                  ph = PhQuoted;
               end
            end else begin
               // octal byte first, then the stray character as quoted text
               expect_word(stu_pkg::KindData, oct_val, 1'b0, 1'b1);
               oct_val = '0;
               oct_cnt = 0;
               ph = PhQuoted;
               quoted_byte(c);
            end
         end
         default: ph = PhIdle;
      endcase
      if (expected_words.size() > size_was) begin
         tail = expected_words.pop_back();
         tail.last = 1'b1;
         append_word(tail);
      end
   endfunction

   task automatic send_char(input logic [stu_pkg::CharWidth-1:0] c, input logic st);
      if (gap_max > 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_start_token <= st;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_taken++;
      if (st || ph != PhIdle) useful_chars++;
      decode_char(c, st);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_text(input string s, input logic first_start);
      for (int i = 0; i < s.len(); i++) send_char(s[i], first_start && i == 0);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      // characters that give no word may still be in flight
      repeat (SettleCycles) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic program_masks();
      for (int i = 0; i < stu_pkg::MaskRegs; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= stu_pkg::MaskIndexWidth'(i);
         csr_wdata <= mask_plan[i];
         @(posedge clock);
         term_mask[i] = mask_plan[i];
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [stu_pkg::CharWidth-1:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return stu_pkg::ChSpace;
         1: return stu_pkg::ChTab;
         2: return stu_pkg::ChLf;
         default: return stu_pkg::ChCr;
      endcase
   endfunction

   task automatic send_token();
      int style;
      logic noisy;
      style = $urandom_range(0, 9);
      noisy = (style == 9);
      token_chars.delete();
      repeat ($urandom_range(0, 2)) add_char(pick_blank());
      if (style < 4) begin
         repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(33, 255)));
         if ($urandom_range(0, 2) != 0) add_char(8'($urandom_range(0, 32)));
         else add_char(8'($urandom_range(0, 255)));
      end else if (!noisy) begin
         add_char(stu_pkg::ChQuote);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: add_char(8'($urandom_range(32, 126)));
               5: add_char(8'($urandom_range(0, 255)));
               default: begin
                  add_char(stu_pkg::ChBackslash);
                  case ($urandom_range(0, 5))
                     0: add_char(stu_pkg::ChLowerN);
                     1: add_char(stu_pkg::ChLowerR);
                     2: add_char(stu_pkg::ChLowerT);
                     3: add_char(stu_pkg::ChLowerB);
                     4: repeat ($urandom_range(1, 3))
                        add_char(ChZero + 8'($urandom_range(0, 7)));
                     default: add_char($urandom_range(0, 1) ? stu_pkg::ChLf
                                       : 8'($urandom_range(0, 255)));
                  endcase
               end
            endcase
         end
         // usually closed by a quote, else by a line end, NUL or the next token
         case ($urandom_range(0, 9))
            6: add_char(stu_pkg::ChLf);
            7: add_char(stu_pkg::ChCr);
            8: add_char(stu_pkg::ChNul);
            9: ;
            default: add_char(stu_pkg::ChQuote);
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
      end
      foreach (token_chars[i])
         send_char(token_chars[i], noisy ? ($urandom_range(0, 3) == 0) : (i == 0));
      tokens_sent++;
   endtask

   task automatic test_directed();
      stall_mode = StallRandom;
      gap_max = 3;
      // ignored while idle
      send_char(8'h78, 1'b0);
      // leading blanks, raw bytes at both ends of the range, space ends it
      send_char(stu_pkg::ChSpace, 1'b1);
      send_char(stu_pkg::ChTab, 1'b0);
      send_char(stu_pkg::ChLf, 1'b0);
      send_char(stu_pkg::ChCr, 1'b0);
      send_char(8'h21, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(stu_pkg::ChSpace, 1'b0);
      // every letter escape, an escaped plain byte, continuation, three-digit octal, octal cut short by the quote
      send_text("\"\\n\\r\\t\\b\\q\\", 1'b1);
      send_char(stu_pkg::ChLf, 1'b0);
      send_text("\\777\\4\"", 1'b0);
      // restart inside an octal run, then NUL straight after a backslash
      send_text("\"\\5", 1'b1);
      send_text("\"\\", 1'b1);
      send_char(stu_pkg::ChNul, 1'b0);
      wait_quiet();
   endtask

   task automatic test_mask_settings();
      int target;
      for (int s = 0; s < MaskSettings; s++) begin
         wait_quiet();
         for (int r = 0; r < stu_pkg::MaskRegs; r++) begin
            case (s)
               0: mask_plan[r] = '1;
               1: mask_plan[r] = '0;
               2, 4: mask_plan[r] = {$urandom & $urandom & $urandom,
                                     $urandom & $urandom & $urandom};
               default: mask_plan[r] = {$urandom, $urandom};
            endcase
         end
         program_masks();
         stall_mode = stall_mode_type'(s % 3);
         gap_max = (s % 4) * 3;
         target = useful_chars + CharsPerSetting;
         while (useful_chars < target) send_token();
      end
      wait_quiet();
   endtask

   task automatic test_stall_pressure();
      stall_mode = StallNone;
      gap_max = 0;
      hold_req++;
      send_char(stu_pkg::ChQuote, 1'b1);
      for (int i = 0; i < PressureChars; i++) send_char(8'("a" + i % 26), 1'b0);
      send_char(stu_pkg::ChQuote, 1'b0);
      tokens_sent++;
      wait_quiet();
   endtask

   // receiver side: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               StallNone: rsp_stall <= 1'b0;
               StallRandom: rsp_stall <= ($urandom_range(0, 2) == 0);
               default: begin
                  rsp_stall <= stall_pat[0];
                  stall_pat <= {stall_pat[0], stall_pat[12:1]};
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word.kind = rsp_kind;
         got_word.value = rsp_value;
         got_word.end_consumed = rsp_end_consumed;
         got_word.was_quoted = rsp_was_quoted;
         got_word.last = rsp_last;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= MaxErrorLines)
               $display("%0t: expected no word, got kind %0b value %02h end %0b quoted %0b last %0b",
                        $time, got_word.kind, got_word.value, got_word.end_consumed,
                        got_word.was_quoted, got_word.last);
         end else begin
            want_word = expected_words.pop_front();
            words_checked++;
            if (got_word.kind !== want_word.kind || got_word.value !== want_word.value ||
                got_word.end_consumed !== want_word.end_consumed ||
                got_word.was_quoted !== want_word.was_quoted ||
                got_word.last !== want_word.last) begin
               errors++;
               if (errors <= MaxErrorLines) begin
                  $display("%0t: expected kind %0b value %02h end %0b quoted %0b last %0b",
                           $time, want_word.kind, want_word.value, want_word.end_consumed,
                           want_word.was_quoted, want_word.last);
                  $display("%0t:      got kind %0b value %02h end %0b quoted %0b last %0b",
                           $time, got_word.kind, got_word.value, got_word.end_consumed,
                           got_word.was_quoted, got_word.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d words still awaited", $time,
                  cycle_count, expected_words.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_mask_settings();
      test_stall_pressure();
      wait_quiet();
      $display("covered %0d characters (%0d parsed) in %0d tokens over %0d terminator masks",
               chars_taken, useful_chars, tokens_sent, MaskSettings);
      $display("checked %0d result words, %0d mismatches", words_checked, errors);
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule
